[hw/rtl/mtfk_pkg.sv]
// mtfk_pkg: types and codes shared by the move-to-front key list
// request and response words, key word and the control word broadcast to the cells
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mtfk_pkg;

   // operation codes
   typedef enum logic [0:0] {
      OP_TOUCH = 1'b0,
      OP_QUERY = 1'b1
   } mtfk_op_type;

   // one input word
   typedef struct packed {
      mtfk_op_type        opcode;
      logic [31:0]        owner_id;
      logic [3:0]         param_kind;
      logic signed [31:0] param_number;
   } mtfk_req_type;

   // one result word
   typedef struct packed {
      logic       hit;
      logic [3:0] entry_count;
   } mtfk_rsp_type;

   // stored key
   typedef struct packed {
      logic [31:0]        owner;
      logic [3:0]         kind;
      logic signed [31:0] param;
   } mtfk_key_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic         touch;
      mtfk_key_type key;
   } mtfk_ctrl_type;

endpackage

`default_nettype wire

[hw/rtl/move_to_front_key_list_core.sv]
// move_to_front_key_list_core: top level of the move-to-front key list
// depends on mtfk_pkg and mtfk_cell
//
// Keeps up to CAPACITY keys (owner, kind, number) in most-recently-used order in a row of
// cells. For each word, all cells compare their key with the request at once, the hit flag
// ripples down the row and stops the shift below the matching cell, and the row shifts by
// one toward the back while cell 0 takes the new key. One word is accepted per cycle while
// req_stall is low; the result appears in an output register the cycle after acceptance,
// and req_stall rises only while that register holds a result the consumer has not taken.
// A touch with owner 0 and every query leave the list unchanged. entry_count carries the low
// four bits of the fill count. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_key_list_core #(
   parameter int CAPACITY = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wire mtfk_pkg::mtfk_req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output mtfk_pkg::mtfk_rsp_type rsp_data
);
   import mtfk_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   mtfk_ctrl_type    ctrl;
   mtfk_key_type     cell_key [CAPACITY];
   logic [CAPACITY:0] seen;
   logic             req_accept;
   logic             owner_ok;
   logic             hit;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   mtfk_rsp_type     rsp_data_ff;
   mtfk_rsp_type     rsp_data_in;

   // handshake: output register frees when taken
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // broadcast key and touch enable
   assign owner_ok       = (req_data.owner_id != 32'd0);
   assign ctrl.key.owner = req_data.owner_id;
   assign ctrl.key.kind  = req_data.param_kind;
   assign ctrl.key.param = req_data.param_number;
   assign ctrl.touch     = req_accept && owner_ok && (req_data.opcode == OP_TOUCH);

   // row of cells, front at index 0
   assign seen[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      mtfk_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .prev_key ((i == 0) ? ctrl.key : cell_key[(i == 0) ? 0 : i - 1]),
         .count    (count_ff),
         .seen_in  (seen[i]),
         .key_out  (cell_key[i]),
         .seen_out (seen[i+1])
      );
   end

   assign hit = seen[CAPACITY] && owner_ok;

   // fill count grows on a touch that misses while there is room
   always_comb begin
      count_in = count_ff;
      if (ctrl.touch && !hit && (count_ff != CNT_W'(CAPACITY))) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.hit         = hit;
         rsp_data_in.entry_count = 4'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[hw/rtl/mtfk_cell.sv]
// mtfk_cell: one slot of the key list, compares against the broadcast key
// and loads its neighbor's key when the list shifts; uses mtfk_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtfk_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 4
) (
   input  wire                   clock,
   input  wire mtfk_pkg::mtfk_ctrl_type ctrl,
   input  wire mtfk_pkg::mtfk_key_type  prev_key,
   input  wire [CNT_W-1:0]       count,
   input  wire                   seen_in,
   output mtfk_pkg::mtfk_key_type  key_out,
   output logic                  seen_out
);
   import mtfk_pkg::*;

   mtfk_key_type key_ff;
   mtfk_key_type key_in;
   logic         live;
   logic         match;
   logic         shift;

   // slot holds a valid entry only below the fill count
   assign live  = (CNT_W'(INDEX) < count);
   assign match = live && (key_ff == ctrl.key);

   // a match further forward stops the shift here
   assign seen_out = seen_in | match;
   assign shift    = ctrl.touch && !seen_in;

   // key register
   always_comb begin
      key_in = shift ? prev_key : key_ff;
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out = key_ff;

endmodule

`default_nettype wire

[hw/rtl/mtfk_checker.sv]
// mtfk_checker: port-level checks for move_to_front_key_list_core
// bound to the top level below; uses mtfk_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtfk_checker #(
   parameter int CAPACITY = 8
) (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input wire mtfk_pkg::mtfk_req_type req_data,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input wire mtfk_pkg::mtfk_rsp_type rsp_data
);
   import mtfk_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // every accepted word yields a result next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word produced no result");

   // a null owner never hits
   a_null_miss: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.owner_id == 32'd0) |=> !rsp_data.hit)
      else $error("null owner reported a hit");

   // count never exceeds the list size (checked only for CAPACITY up to 15)
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 15) || (int'(rsp_data.entry_count) <= CAPACITY))
      else $error("entry count above capacity");

   // a touch with a nonzero owner followed by a query of that key hits
   a_touch_then_query: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.opcode == OP_TOUCH) &&
      (req_data.owner_id != 32'd0) ##1
      req_valid && !req_stall && (req_data.opcode == OP_QUERY) &&
      (req_data == {OP_QUERY, $past(req_data.owner_id), $past(req_data.param_kind),
                    $past(req_data.param_number)})
      |=> rsp_data.hit)
      else $error("key missing right after touch");

endmodule

bind move_to_front_key_list_core mtfk_checker #(.CAPACITY(CAPACITY)) u_mtfk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
